// File: hdl/gtd_pkg.sv
`default_nettype none

package gtd_pkg;

  localparam int unsigned COUNT_W = 14;
  localparam int unsigned REM_W = 10;
  localparam int unsigned WEIGHT_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 14'd9999;
  localparam logic [COUNT_W-1:0] FULL_TIME_RESET = 14'd360;
  localparam logic [COUNT_W-1:0] HALF_TIME_RESET = 14'd180;
  localparam logic [COUNT_W-1:0] SINGLE_TIME_RESET = 14'd30;

  localparam logic [WEIGHT_W-1:0] WEIGHT_THOUSANDS = 10'd1000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HUNDREDS = 10'd100;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TENS = 10'd10;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  localparam logic [1:0] REG_FULL_TIME = 2'd0;
  localparam logic [1:0] REG_HALF_TIME = 2'd1;
  localparam logic [1:0] REG_SINGLE_TIME = 2'd2;

  localparam logic [1:0] DIGIT_THOUSANDS = 2'd0;
  localparam logic [1:0] DIGIT_HUNDREDS = 2'd1;
  localparam logic [1:0] DIGIT_TENS = 2'd2;
  localparam logic [1:0] DIGIT_TENTHS = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_SPLIT  = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic split_run;
    logic split_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [6:0] glyph(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0: seg = 7'h3F;
      4'd1: seg = 7'h06;
      4'd2: seg = 7'h5B;
      4'd3: seg = 7'h4F;
      4'd4: seg = 7'h66;
      4'd5: seg = 7'h6D;
      4'd6: seg = 7'h7D;
      4'd7: seg = 7'h07;
      4'd8: seg = 7'h7F;
      4'd9: seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// File: hdl/gtd_ctrl.sv
`default_nettype none

module gtd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gtd_pkg::dp_status_t status,
  output gtd_pkg::ctl_cmd_t        cmd
);

  gtd_pkg::state_t state;
  gtd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gtd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = gtd_pkg::S_EXEC;
        end
      end
      gtd_pkg::S_EXEC: begin
        if (status.split_run) begin
          state_next = gtd_pkg::S_SPLIT;
        end else begin
          state_next = gtd_pkg::S_FINISH;
        end
      end
      gtd_pkg::S_SPLIT: begin
        if (status.split_done) begin
          state_next = gtd_pkg::S_FINISH;
        end
      end
      gtd_pkg::S_FINISH: begin
        if (status.out_free) begin
          state_next = gtd_pkg::S_IDLE;
        end
      end
      default: state_next = gtd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      gtd_pkg::S_IDLE: begin
        in_stall = rst;
        cmd.capture = in_valid && !rst;
      end
      gtd_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      gtd_pkg::S_SPLIT: begin
        cmd.step = ~status.split_done;
      end
      gtd_pkg::S_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/gtd_datapath.sv
`default_nettype none

module gtd_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gtd_pkg::ctl_cmd_t   cmd,
  output gtd_pkg::dp_status_t      status,
  input  wire logic [1:0]          opcode,
  input  wire logic [3:0]          buttons_n,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [13:0]         cfg_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     motor_on,
  output logic [3:0]               digit_select,
  output logic [6:0]               segments,
  output logic                     decimal_point,
  output logic [13:0]              count_tenths
);

  logic [1:0] op_q;
  logic [3:0] buttons_q;
  logic [13:0] full_time;
  logic [13:0] half_time;
  logic [13:0] single_time;
  logic [13:0] count;
  gtd_pkg::mode_t mode;
  logic [1:0] digit_index;
  logic [9:0] remainder;
  logic [13:0] work;
  logic [9:0] weight;
  logic [3:0] digit;
  logic show;

  logic [13:0] count_next;
  gtd_pkg::mode_t mode_next;
  logic [1:0] digit_index_next;
  logic [3:0] pressed;
  logic [13:0] add_time;
  logic [14:0] sum;
  logic [13:0] sum_sat;
  logic refresh_run;
  logic [13:0] shown_value;

  assign pressed = ~buttons_q;
  assign refresh_run = (op_q == gtd_pkg::OP_REFRESH) && (mode != gtd_pkg::MODE_IDLE);

  always_comb begin
    if (pressed[1]) begin
      add_time = full_time;
    end else if (pressed[2]) begin
      add_time = half_time;
    end else begin
      add_time = single_time;
    end
    sum = {1'b0, count} + {1'b0, add_time};
    sum_sat = (sum > {1'b0, gtd_pkg::COUNT_MAX}) ? gtd_pkg::COUNT_MAX : sum[13:0];
  end

  always_comb begin
    count_next = count;
    mode_next = mode;
    digit_index_next = digit_index;
    case (op_q)
      gtd_pkg::OP_TICK: begin
        if (mode == gtd_pkg::MODE_DOWN) begin
          if (count != '0) begin
            count_next = count - 14'd1;
          end
          if (count_next == '0) begin
            mode_next = gtd_pkg::MODE_IDLE;
            digit_index_next = gtd_pkg::DIGIT_THOUSANDS;
          end
        end else if (mode == gtd_pkg::MODE_UP && count < gtd_pkg::COUNT_MAX) begin
          count_next = count + 14'd1;
        end
      end
      gtd_pkg::OP_BUTTON: begin
        if (pressed[0]) begin
          count_next = '0;
          mode_next = gtd_pkg::MODE_UP;
        end else if (pressed[3:1] != 3'b000) begin
          count_next = sum_sat;
          mode_next = gtd_pkg::MODE_DOWN;
        end else if (mode == gtd_pkg::MODE_UP) begin
          count_next = '0;
          mode_next = gtd_pkg::MODE_IDLE;
        end
        if (mode_next == gtd_pkg::MODE_IDLE || mode == gtd_pkg::MODE_IDLE) begin
          digit_index_next = gtd_pkg::DIGIT_THOUSANDS;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign status.split_run = refresh_run && (digit_index != gtd_pkg::DIGIT_TENTHS);
  assign status.split_done = !((work >= {4'b0000, weight}) && (digit < gtd_pkg::DIGIT_MAX));
  assign status.out_free = !out_valid || !out_stall;

  assign shown_value = (digit_index == gtd_pkg::DIGIT_TENTHS) ? work : {10'b0, digit};

  always_ff @(posedge clk) begin
    if (rst) begin
      full_time <= gtd_pkg::FULL_TIME_RESET;
      half_time <= gtd_pkg::HALF_TIME_RESET;
      single_time <= gtd_pkg::SINGLE_TIME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        gtd_pkg::REG_FULL_TIME: full_time <= cfg_data;
        gtd_pkg::REG_HALF_TIME: half_time <= cfg_data;
        gtd_pkg::REG_SINGLE_TIME: single_time <= cfg_data;
        default: full_time <= full_time;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= opcode;
      buttons_q <= buttons_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      show <= refresh_run;
      digit <= '0;
      work <= (digit_index == gtd_pkg::DIGIT_THOUSANDS) ? count : {4'b0000, remainder};
      case (digit_index)
        gtd_pkg::DIGIT_THOUSANDS: weight <= gtd_pkg::WEIGHT_THOUSANDS;
        gtd_pkg::DIGIT_HUNDREDS: weight <= gtd_pkg::WEIGHT_HUNDREDS;
        default: weight <= gtd_pkg::WEIGHT_TENS;
      endcase
    end else if (cmd.step) begin
      work <= work - {4'b0000, weight};
      digit <= digit + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mode <= gtd_pkg::MODE_IDLE;
      digit_index <= '0;
      remainder <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
      mode <= mode_next;
      digit_index <= digit_index_next;
    end else if (cmd.finish && show) begin
      remainder <= work[9:0];
      digit_index <= digit_index + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      motor_on <= (mode != gtd_pkg::MODE_IDLE);
      count_tenths <= count;
      if (show) begin
        digit_select <= 4'b0001 << digit_index;
        segments <= (shown_value < 14'd10) ? gtd_pkg::glyph(shown_value[3:0]) : 7'h00;
        decimal_point <= (digit_index == gtd_pkg::DIGIT_TENS);
      end else begin
        digit_select <= '0;
        segments <= '0;
        decimal_point <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/grind_timer_with_display.sv
// Channel   Handshake               Payload
// input     in_valid / in_stall     opcode, buttons_n
// output    out_valid / out_stall   motor_on, digit_select, segments, decimal_point,
//                                   count_tenths
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item passes the idle, execute and finish states; a refresh strobe that splits a digit also
// runs the split state: one step per cycle (up to 9) in the shared subtract-and-compare unit.
// The result sits in an output register, so the next item is taken while it waits.
// A stalled output holds the controller in its final state until the register frees up.
// Synchronous reset restores the count, mode, digit index and the three time registers;
// the input and the configuration port hold off while reset is high.
`default_nettype none

module grind_timer_with_display (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  buttons_n,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             motor_on,
  output logic [3:0]       digit_select,
  output logic [6:0]       segments,
  output logic             decimal_point,
  output logic [13:0]      count_tenths,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  gtd_pkg::ctl_cmd_t cmd;
  gtd_pkg::dp_status_t status;

  assign cfg_ready = !rst;

  gtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gtd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (opcode),
    .buttons_n     (buttons_n),
    .cfg_write     (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motor_on      (motor_on),
    .digit_select  (digit_select),
    .segments      (segments),
    .decimal_point (decimal_point),
    .count_tenths  (count_tenths)
  );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] BTN_NONE = 4'hF;
  localparam logic [3:0] BTN_MANUAL = 4'hE;
  localparam logic [3:0] BTN_FULL = 4'hD;
  localparam logic [3:0] BTN_HALF = 4'hB;
  localparam logic [3:0] BTN_SINGLE = 4'h7;
  localparam logic [3:0] BUTTON_CODES [4] = '{BTN_MANUAL, BTN_FULL, BTN_HALF, BTN_SINGLE};
  localparam logic [1:0] TIME_REGS [3] = '{gtd_pkg::REG_FULL_TIME, gtd_pkg::REG_HALF_TIME,
                                           gtd_pkg::REG_SINGLE_TIME};
  localparam logic [6:0] GLYPH_ROM [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                           7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES = 11;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned UP_TICKS = 25;
  localparam int N_DIRECTED = 26;

  typedef struct packed {
    logic        motor_on;
    logic [3:0]  digit_select;
    logic [6:0]  segments;
    logic        decimal_point;
    logic [13:0] count_tenths;
  } frame_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] btn;
    logic       typed;
    frame_t     want;
  } vector_t;

  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{gtd_pkg::OP_TICK,    BTN_NONE,   1'b1, '0},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b1, '0},
    '{OP_UNUSED,           BTN_NONE,   1'b1, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_NONE,   1'b1, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_SINGLE, 1'b1, '{1'b1, 4'h0, 7'h00, 1'b0, 14'd30}},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b1, '{1'b1, 4'h1, 7'h3F, 1'b0, 14'd30}},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b1, '{1'b1, 4'h2, 7'h3F, 1'b0, 14'd30}},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b1, '{1'b1, 4'h4, 7'h4F, 1'b1, 14'd30}},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b1, '{1'b1, 4'h8, 7'h3F, 1'b0, 14'd30}},
    '{gtd_pkg::OP_TICK,    BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_HALF,   1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_FULL,   1'b0, '0},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  4'h0,       1'b1, '{1'b1, 4'h0, 7'h00, 1'b0, 14'd0}},
    '{gtd_pkg::OP_TICK,    BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_MANUAL, 1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_NONE,   1'b1, '0},
    '{gtd_pkg::OP_BUTTON,  4'h6,       1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  4'h9,       1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  4'h3,       1'b0, '0},
    '{gtd_pkg::OP_REFRESH, BTN_NONE,   1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_MANUAL, 1'b0, '0},
    '{gtd_pkg::OP_BUTTON,  BTN_NONE,   1'b1, '0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [3:0]  buttons_n;
  logic        out_valid;
  logic        out_stall;
  logic        motor_on;
  logic [3:0]  digit_select;
  logic [6:0]  segments;
  logic        decimal_point;
  logic [13:0] count_tenths;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;

  logic [13:0]     timer_count;
  gtd_pkg::mode_t  timer_mode;
  logic [1:0]      digit_pos;
  logic [gtd_pkg::REM_W-1:0] digit_rest;
  logic [13:0]     button_time [3];

  frame_t      expected_frames [$];
  frame_t      head_frame;
  bit          failed;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned stuck_cycles;

  grind_timer_with_display DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .buttons_n(buttons_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .motor_on(motor_on),
    .digit_select(digit_select),
    .segments(segments),
    .decimal_point(decimal_point),
    .count_tenths(count_tenths),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void add_time(input logic [1:0] idx);
    int unsigned sum;
    sum = 32'(timer_count) + 32'(button_time[idx]);
    timer_count = (sum > 32'(gtd_pkg::COUNT_MAX)) ? gtd_pkg::COUNT_MAX : sum[13:0];
    timer_mode = gtd_pkg::MODE_DOWN;
  endfunction

  function automatic frame_t advance_timer(input logic [1:0] op, input logic [3:0] btn);
    logic [3:0]     pressed;
    gtd_pkg::mode_t was;
    int unsigned    rest;
    int unsigned    digit;
    int unsigned    weight;
    frame_t         f;
    pressed = ~btn;
    was = timer_mode;
    f = '0;
    if (op == gtd_pkg::OP_TICK) begin
      if (timer_mode == gtd_pkg::MODE_DOWN && timer_count != 0) timer_count--;
      else if (timer_mode == gtd_pkg::MODE_UP && timer_count < gtd_pkg::COUNT_MAX)
        timer_count++;
      if (timer_mode == gtd_pkg::MODE_DOWN && timer_count == 0) begin
        timer_mode = gtd_pkg::MODE_IDLE;
        digit_pos = gtd_pkg::DIGIT_THOUSANDS;
      end
    end else if (op == gtd_pkg::OP_BUTTON) begin
      if (pressed[0]) begin
        timer_count = '0;
        timer_mode = gtd_pkg::MODE_UP;
      end else if (pressed[1]) begin
        add_time(gtd_pkg::REG_FULL_TIME);
      end else if (pressed[2]) begin
        add_time(gtd_pkg::REG_HALF_TIME);
      end else if (pressed[3]) begin
        add_time(gtd_pkg::REG_SINGLE_TIME);
      end else if (timer_mode == gtd_pkg::MODE_UP) begin
        timer_count = '0;
        timer_mode = gtd_pkg::MODE_IDLE;
      end
      if (timer_mode == gtd_pkg::MODE_IDLE || was == gtd_pkg::MODE_IDLE)
        digit_pos = gtd_pkg::DIGIT_THOUSANDS;
    end else if (op == gtd_pkg::OP_REFRESH && timer_mode != gtd_pkg::MODE_IDLE) begin
      rest = (digit_pos == gtd_pkg::DIGIT_THOUSANDS) ? 32'(timer_count) : 32'(digit_rest);
      case (digit_pos)
        gtd_pkg::DIGIT_THOUSANDS: weight = 32'(gtd_pkg::WEIGHT_THOUSANDS);
        gtd_pkg::DIGIT_HUNDREDS: weight = 32'(gtd_pkg::WEIGHT_HUNDREDS);
        default: weight = 32'(gtd_pkg::WEIGHT_TENS);
      endcase
      if (digit_pos == gtd_pkg::DIGIT_TENTHS) begin
        digit = rest;
      end else begin
        digit = rest / weight;
        if (digit > 32'(gtd_pkg::DIGIT_MAX)) digit = 32'(gtd_pkg::DIGIT_MAX);
        rest = rest - digit * weight;
      end
      digit_rest = rest[gtd_pkg::REM_W-1:0];
      f.digit_select = 4'b0001 << digit_pos;
      f.segments = (digit <= 32'(gtd_pkg::DIGIT_MAX)) ? GLYPH_ROM[digit] : '0;
      f.decimal_point = (digit_pos == gtd_pkg::DIGIT_TENS);
      digit_pos++;
    end
    f.motor_on = (timer_mode != gtd_pkg::MODE_IDLE);
    f.count_tenths = timer_count;
    return f;
  endfunction

  task automatic send(input logic [1:0] op, input logic [3:0] btn, input logic typed,
                      input frame_t want);
    frame_t predicted;
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    buttons_n <= btn;
    do @(posedge clk); while (in_stall);
    predicted = advance_timer(op, btn);
    expected_frames.push_back(typed ? want : predicted);
  endtask

  task automatic send_random();
    int unsigned r;
    int unsigned k;
    logic [1:0]  op;
    logic [3:0]  btn;
    r = $urandom_range(99);
    if (r < 45) op = gtd_pkg::OP_TICK;
    else if (r < 70) op = gtd_pkg::OP_REFRESH;
    else if (r < 95) op = gtd_pkg::OP_BUTTON;
    else op = OP_UNUSED;
    k = $urandom_range(9);
    if (k < 4) btn = BUTTON_CODES[k];
    else if (k < 7) btn = BTN_NONE;
    else btn = 4'($urandom_range(15));
    send(op, btn, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
  endtask

  task automatic write_times(input logic [13:0] full, input logic [13:0] half,
                             input logic [13:0] single);
    logic [13:0] vals [3];
    vals[0] = full;
    vals[1] = half;
    vals[2] = single;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= TIME_REGS[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      button_time[TIME_REGS[i]] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("Result transaction with nothing pending: count_tenths %0d", count_tenths);
        failed = 1'b1;
      end else begin
        head_frame = expected_frames.pop_front();
        if (motor_on !== head_frame.motor_on) begin
          $error("motor_on: expected %0d, got %0d", head_frame.motor_on, motor_on);
          failed = 1'b1;
        end
        if (digit_select !== head_frame.digit_select) begin
          $error("digit_select: expected %0h, got %0h", head_frame.digit_select, digit_select);
          failed = 1'b1;
        end
        if (segments !== head_frame.segments) begin
          $error("segments: expected %0h, got %0h", head_frame.segments, segments);
          failed = 1'b1;
        end
        if (decimal_point !== head_frame.decimal_point) begin
          $error("decimal_point: expected %0d, got %0d", head_frame.decimal_point,
                 decimal_point);
          failed = 1'b1;
        end
        if (count_tenths !== head_frame.count_tenths) begin
          $error("count_tenths: expected %0d, got %0d", head_frame.count_tenths, count_tenths);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [13:0] tf;
    logic [13:0] th;
    logic [13:0] ts;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = gtd_pkg::OP_TICK;
    buttons_n = BTN_NONE;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = gtd_pkg::REG_FULL_TIME;
    cfg_data = '0;
    failed = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stuck_cycles = 0;
    timer_count = '0;
    timer_mode = gtd_pkg::MODE_IDLE;
    digit_pos = gtd_pkg::DIGIT_THOUSANDS;
    digit_rest = '0;
    button_time[gtd_pkg::REG_FULL_TIME] = gtd_pkg::FULL_TIME_RESET;
    button_time[gtd_pkg::REG_HALF_TIME] = gtd_pkg::HALF_TIME_RESET;
    button_time[gtd_pkg::REG_SINGLE_TIME] = gtd_pkg::SINGLE_TIME_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send(DIRECTED[i].op, DIRECTED[i].btn, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          tf = '0;
          th = '0;
          ts = '0;
        end
        1: begin
          tf = gtd_pkg::COUNT_MAX;
          th = gtd_pkg::COUNT_MAX;
          ts = gtd_pkg::COUNT_MAX;
        end
        2: begin
          tf = '1;
          th = gtd_pkg::COUNT_MAX + 14'd1;
          ts = gtd_pkg::COUNT_MAX - 14'd1;
        end
        default: begin
          if (p % 3 == 0) begin
            tf = 14'($urandom_range(gtd_pkg::COUNT_MAX));
            th = 14'($urandom_range(gtd_pkg::COUNT_MAX));
            ts = 14'($urandom_range(gtd_pkg::COUNT_MAX));
          end else begin
            tf = 14'($urandom_range(40));
            th = 14'($urandom_range(40));
            ts = 14'($urandom_range(40));
          end
        end
      endcase
      write_times(tf, th, ts);
      quiet = (p == 4);
      if (p == 5) hold_req = 1'b1;
      send(gtd_pkg::OP_BUTTON, BTN_MANUAL, 1'b0, '0);
      send(gtd_pkg::OP_BUTTON, BTN_NONE, 1'b0, '0);
      send(gtd_pkg::OP_BUTTON, BTN_SINGLE, 1'b0, '0);
      send(gtd_pkg::OP_TICK, BTN_NONE, 1'b0, '0);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    quiet = 1'b0;
    send(gtd_pkg::OP_BUTTON, BTN_MANUAL, 1'b0, '0);
    repeat (UP_TICKS) send(gtd_pkg::OP_TICK, BTN_NONE, 1'b0, '0);
    repeat (4) send(gtd_pkg::OP_REFRESH, BTN_NONE, 1'b0, '0);
    send(gtd_pkg::OP_BUTTON, BTN_NONE, 1'b0, '0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
hdl/gtd_pkg.sv
hdl/gtd_ctrl.sv
hdl/gtd_datapath.sv
hdl/grind_timer_with_display.sv
verif/tb.sv
